### hw/rtl/prle_pkg.sv
// Shared types and constants of the palette run-length encoder.
`default_nettype none

package prle_pkg;

	localparam int RGB_W      = 24;
	localparam int IDX_W      = 8;
	localparam int CFG_W      = 13;
	localparam int LEN_W      = 13;
	localparam int PCNT_W     = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int PIXEL_W    = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 1'b1;

	localparam logic KIND_ENTRY = 1'b0;
	localparam logic KIND_RUN   = 1'b1;

	// Output stream: index, red, green, blue, run length, runs in line,
	// palette count, end of line, last result.
	localparam int OUT_PAYLOAD_W = IDX_W + 3 * 8 + LEN_W + LEN_W + PCNT_W + 2;
	localparam int OUT_DATA_W    = ((OUT_PAYLOAD_W + 7) / 8) * 8;

	// Position flags of a pixel, decided when it enters.
	typedef struct packed {
		logic col0;
		logic eol;
		logic eot;
	} prle_pos_t;

	// One pixel travelling along the palette chain.
	typedef struct packed {
		logic             valid;
		logic [RGB_W-1:0] rgb;
		prle_pos_t        pos;
		logic             found;
		logic             fresh;
		logic [IDX_W-1:0] idx;
	} prle_token_t;

	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  idx;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [LEN_W-1:0]  run_length;
		logic [LEN_W-1:0]  runs_in_line;
		logic [PCNT_W-1:0] palette_count;
		logic              end_of_line;
		logic              end_of_tile;
		logic              last_result;
	} prle_result_t;

endpackage

`default_nettype wire

### hw/rtl/prle_position.sv
// Size registers and column and row counters that mark line and tile ends.
`default_nettype none

module prle_position #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [prle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [prle_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          accept,
	output prle_pkg::prle_pos_t                pos
);
	import prle_pkg::*;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WC_W  = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
	localparam int HC_W  = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 1;

	logic [CFG_W-1:0] line_width_q;
	logic [CFG_W-1:0] tile_height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [WC_W-1:0]  width_c;
	logic [HC_W-1:0]  height_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q  <= CFG_W'(1);
			tile_height_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LINE_WIDTH:  line_width_q  <= cfg_data;
				CFG_TILE_HEIGHT: tile_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A size of zero counts as one; a size above the maximum is clamped.
	always_comb begin
		if (line_width_q == '0)
			width_c = WC_W'(1);
		else if (WC_W'(line_width_q) > WC_W'(MAX_WIDTH))
			width_c = WC_W'(MAX_WIDTH);
		else
			width_c = WC_W'(line_width_q);
		if (tile_height_q == '0)
			height_c = HC_W'(1);
		else if (HC_W'(tile_height_q) > HC_W'(MAX_HEIGHT))
			height_c = HC_W'(MAX_HEIGHT);
		else
			height_c = HC_W'(tile_height_q);
	end

	assign pos.col0 = (col_q == '0);
	assign pos.eol  = (WC_W'(col_q) + WC_W'(1)) >= width_c;
	assign pos.eot  = pos.eol && ((HC_W'(row_q) + HC_W'(1)) >= height_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (pos.eol) begin
				col_q <= '0;
				row_q <= pos.eot ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/prle_cell.sv
// One palette cell: holds one colour and matches or claims it for passing pixels.
`default_nettype none

module prle_cell #(
	parameter logic [7:0] IDX = 8'd0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  prle_pkg::prle_token_t  tok_in,
	output prle_pkg::prle_token_t  tok_out
);
	import prle_pkg::*;

	logic [RGB_W-1:0] colour_q;
	logic             used_q;
	prle_token_t      tok_q;
	prle_token_t      tok_next;
	logic             hit;
	logic             claim;

	assign hit   = tok_in.valid && !tok_in.found && used_q && (colour_q == tok_in.rgb);
	assign claim = tok_in.valid && !tok_in.found && !used_q;

	always_comb begin
		tok_next = tok_in;
		if (hit || claim) begin
			tok_next.found = 1'b1;
			tok_next.idx   = IDX;
		end
		if (claim)
			tok_next.fresh = 1'b1;
	end

	// The tile's last pixel empties every cell as it passes, so pixels
	// behind it find an empty palette.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			tok_q  <= '0;
		end else if (advance) begin
			tok_q <= tok_next;
			if (tok_in.valid && tok_in.pos.eot)
				used_q <= 1'b0;
			else if (claim)
				used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && claim)
			colour_q <= tok_in.rgb;
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

### hw/rtl/prle_emit.sv
// Run tracking and result sequencing behind the palette chain, with the output register.
`default_nettype none

module prle_emit #(
	parameter int MAX_WIDTH     = 4096,
	parameter int PALETTE_DEPTH = 255
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  prle_pkg::prle_token_t  tok,
	output logic                   tail_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output prle_pkg::prle_result_t out_result
);
	import prle_pkg::*;

	localparam int RUN_W = $clog2(MAX_WIDTH + 1);

	// Pending results of the held pixel: closing run, palette entry, line-end run.
	logic [2:0]        mask_q;
	logic [2:0]        low;
	logic [2:0]        mask_after;
	logic              emit;
	logic              load;

	logic [IDX_W-1:0]  close_idx_q;
	logic [RUN_W-1:0]  close_len_q;
	logic [IDX_W-1:0]  new_idx_q;
	logic [RGB_W-1:0]  rgb_q;
	logic [RUN_W-1:0]  eol_len_q;
	logic [RUN_W-1:0]  eol_runs_q;
	logic [PCNT_W-1:0] pcount_q;
	logic              eot_q;

	logic [RGB_W-1:0]  prev_colour_q;
	logic [IDX_W-1:0]  prev_idx_q;
	logic [RUN_W-1:0]  run_q;
	logic [RUN_W-1:0]  line_runs_q;
	logic [PCNT_W-1:0] colours_q;

	logic              change;
	logic [IDX_W-1:0]  idx_c;
	logic [RUN_W-1:0]  run_new;
	logic [RUN_W-1:0]  lines_new;
	logic [PCNT_W-1:0] colours_new;

	logic              out_valid_q;
	prle_result_t      out_q;
	prle_result_t      sel;

	assign change      = !tok.pos.col0 && (tok.rgb != prev_colour_q);
	assign idx_c       = tok.found ? tok.idx : '0;
	assign run_new     = ((tok.pos.col0 || change) ? '0 : run_q) + RUN_W'(1);
	assign lines_new   = tok.pos.col0 ? '0 : line_runs_q + RUN_W'(change);
	assign colours_new = colours_q + PCNT_W'(tok.fresh);

	assign low        = mask_q & (~mask_q + 3'd1);
	assign mask_after = mask_q & ~low;
	assign emit       = (mask_q != '0) && (!out_valid_q || out_ready);
	assign tail_ready = (mask_q == '0) || (emit && (mask_after == '0));
	assign load       = tail_ready && tok.valid;

	always_comb begin
		sel             = '0;
		sel.last_result = (mask_after == '0);
		priority if (low[0]) begin
			sel.kind       = KIND_RUN;
			sel.idx        = close_idx_q;
			sel.run_length = LEN_W'(close_len_q);
		end else if (low[1]) begin
			sel.kind  = KIND_ENTRY;
			sel.idx   = new_idx_q;
			sel.red   = rgb_q[23:16];
			sel.green = rgb_q[15:8];
			sel.blue  = rgb_q[7:0];
		end else begin
			sel.kind          = KIND_RUN;
			sel.idx           = new_idx_q;
			sel.run_length    = LEN_W'(eol_len_q);
			sel.runs_in_line  = LEN_W'(eol_runs_q);
			sel.palette_count = pcount_q;
			sel.end_of_line   = 1'b1;
			sel.end_of_tile   = eot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			prev_idx_q  <= '0;
			run_q       <= '0;
			line_runs_q <= '0;
			colours_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q     <= {tok.pos.eol, tok.fresh, change};
				prev_idx_q <= idx_c;
				if (tok.pos.eol) begin
					run_q       <= '0;
					line_runs_q <= '0;
				end else begin
					run_q       <= run_new;
					line_runs_q <= lines_new;
				end
				colours_q <= tok.pos.eot ? '0 : colours_new;
			end else if (emit) begin
				mask_q <= mask_after;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			close_idx_q   <= prev_idx_q;
			close_len_q   <= run_q;
			new_idx_q     <= idx_c;
			rgb_q         <= tok.rgb;
			eol_len_q     <= run_new;
			eol_runs_q    <= lines_new + RUN_W'(1);
			pcount_q      <= tok.pos.eot ? colours_new : '0;
			eot_q         <= tok.pos.eot;
			prev_colour_q <= tok.rgb;
		end
		if (emit)
			out_q <= sel;
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	a_colours_bound: assert property (@(posedge clk) disable iff (!arst_n)
		colours_q <= PCNT_W'(PALETTE_DEPTH))
		else $error("palette count beyond palette depth");

	a_eot_is_eol_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.end_of_tile |-> out_q.end_of_line && out_q.kind == KIND_RUN)
		else $error("tile end on a result that is not a line-end run");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (mask_after == '0) |=> out_q.last_result)
		else $error("final result of a pixel lacks its last flag");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (mask_q == '0) || (emit && mask_after == '0))
		else $error("pixel loaded over pending results");

endmodule

`default_nettype wire

### hw/rtl/palette_run_length_encoder_top.sv
// Top level of the palette run-length encoder: size registers, palette cell chain, result sequencer.
`default_nettype none

// Channel    Direction  Payload
// s_axis     in         tdata[31:0]: pixel, red 31..24, green 23..16, blue 15..8, alpha unused
// m_axis     out        tdata: palette entry or run; tuser: kind; tlast: end of tile
// cfg        in         cfg_index 0 line width, 1 tile height; cfg_data 13 bits
//
// Every pixel walks the palette chain, one cell per cycle while the chain advances, so a
// pixel's first result appears only after it has passed every palette cell.
// A pixel is accepted in every cycle while the result sequencer keeps pace; a pixel
// that causes more than one result holds the sequencer, one result per cycle while m_axis is ready.
// The whole chain and the input stall together while the sequencer waits on m_axis.
// Reset empties the palette and the counters at once, sets both sizes to one, and
// needs no clearing pass.
module palette_run_length_encoder_top #(
	parameter int MAX_WIDTH     = 4096,
	parameter int MAX_HEIGHT    = 4096,
	parameter int PALETTE_DEPTH = 255
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration write port.
	input  wire logic                             cfg_we,
	input  wire logic [prle_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [prle_pkg::CFG_W-1:0]       cfg_data,
	// Pixel items in.
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [prle_pkg::PIXEL_W-1:0]     s_axis_tdata,   // pixel_rgba
	// Result items out.
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// From bit 0: color_index, red, green, blue, run_length, runs_in_line,
	// palette_count, end_of_line, last_result, zero padding.
	output logic [prle_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	output logic                                  m_axis_tuser,   // result_kind
	output logic                                  m_axis_tlast    // end_of_tile
);
	import prle_pkg::*;

	prle_pos_t    pos;
	prle_token_t  chain [PALETTE_DEPTH+1];
	prle_result_t result;
	logic         advance;
	logic         accept;

	assign s_axis_tready = advance;
	assign accept        = s_axis_tvalid && advance;

	// Line and tile ends are decided as the pixel enters, so that the sizes in
	// force at that moment govern it.
	prle_position #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_position (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.pos       (pos)
	);

	always_comb begin
		chain[0]       = '0;
		chain[0].valid = s_axis_tvalid;
		chain[0].rgb   = s_axis_tdata[31:8];
		chain[0].pos   = pos;
	end

	// Cell i holds palette entry i. Entries fill in order, so the first empty
	// cell a pixel reaches is the next free index; pixels behind see its claim.
	for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
		prle_cell #(
			.IDX (8'(i))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	// A pixel that leaves the chain unmatched met a full palette and takes index 0.
	prle_emit #(
		.MAX_WIDTH     (MAX_WIDTH),
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok        (chain[PALETTE_DEPTH]),
		.tail_ready (advance),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	assign m_axis_tdata = {{(OUT_DATA_W - OUT_PAYLOAD_W){1'b0}},
		result.last_result, result.end_of_line, result.palette_count,
		result.runs_in_line, result.run_length, result.blue, result.green,
		result.red, result.idx};
	assign m_axis_tuser = result.kind;
	assign m_axis_tlast = result.end_of_tile;

endmodule

`default_nettype wire

### tb/sv/tb_palette_run_length_encoder_top.sv
// Self-checking testbench for the palette run-length encoder top level.
module tb_palette_run_length_encoder_top;
	import prle_pkg::*;

	// Sizes the encoder is built with; the predictor uses the same values.
	localparam int MAX_SIDE  = 4096;
	localparam int PAL_SLOTS = 255;
	// A pixel's first result comes only after it has passed every palette cell.
	// This margin covers a pixel that causes no result but is still in flight.
	localparam int SETTLE_CYCLES = PAL_SLOTS + 40;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [PIXEL_W-1:0]       s_axis_tdata = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]    m_axis_tdata;
	logic                     m_axis_tuser;
	logic                     m_axis_tlast;

	palette_run_length_encoder_top #(
		.MAX_WIDTH    (MAX_SIDE),
		.MAX_HEIGHT   (MAX_SIDE),
		.PALETTE_DEPTH(PAL_SLOTS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Pixels waiting to be offered, and the results the encoder still owes us.
	logic [PIXEL_W-1:0] pixels_to_send [$];
	prle_result_t       encoder_outputs_due [$];
	int                 mismatch_count = 0;

	// The testbench's own copy of the encoder state and of the two size registers.
	logic [CFG_W-1:0]   line_width_q = 13'd1;
	logic [CFG_W-1:0]   tile_height_q = 13'd1;
	logic [RGB_W-1:0]   palette_mem [PAL_SLOTS];
	int                 colours_in_use = 0;
	logic [RGB_W-1:0]   last_rgb = '0;
	logic [IDX_W-1:0]   last_idx = '0;
	int                 run_len = 0;
	int                 col_pos = 0;
	int                 row_pos = 0;
	int                 runs_done = 0;

	// Set at each rising edge when a pixel item was taken; read at the next falling edge.
	bit                 px_fired = 1'b0;
	int                 px_gap = 0;
	int                 px_calm = 0;
	int                 res_stall = 0;
	int                 res_calm = 0;

	// A register value of zero means one, and anything above the maximum means the maximum.
	function automatic int eff_size(logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_SIDE)
			return MAX_SIDE;
		return v;
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Works out the results of one accepted pixel and appends them, in order, to the
	// store of due results. The order is: the run closed by a colour change, then the
	// entry for a newly seen colour, then the run that finishes the line.
	function automatic void encode_pixel(logic [PIXEL_W-1:0] px);
		logic [RGB_W-1:0] rgb;
		prle_result_t     made [3];
		int               n;
		int               idx;
		int               i;
		bit               found;
		bit               eot;
		int               w;
		int               h;

		rgb = px[31:8];
		w = eff_size(line_width_q);
		h = eff_size(tile_height_q);
		n = 0;

		if (col_pos == 0) begin
			run_len = 0;
			runs_done = 0;
		end else if (rgb != last_rgb) begin
			made[n] = '0;
			made[n].kind = KIND_RUN;
			made[n].idx = last_idx;
			made[n].run_length = LEN_W'(run_len);
			n++;
			runs_done++;
			run_len = 0;
		end

		found = 1'b0;
		idx = 0;
		for (i = 0; i < colours_in_use; i++) begin
			if (!found && palette_mem[i] == rgb) begin
				idx = i;
				found = 1'b1;
			end
		end
		// Once the palette is full an unseen colour silently takes index zero.
		if (!found && colours_in_use < PAL_SLOTS) begin
			idx = colours_in_use;
			palette_mem[idx] = rgb;
			colours_in_use++;
			made[n] = '0;
			made[n].kind = KIND_ENTRY;
			made[n].idx = IDX_W'(idx);
			made[n].red = rgb[23:16];
			made[n].green = rgb[15:8];
			made[n].blue = rgb[7:0];
			n++;
		end

		run_len++;
		last_rgb = rgb;
		last_idx = IDX_W'(idx);

		// Positions are never reset by a size change, hence the comparison rather than
		// an equality test.
		if (col_pos + 1 >= w) begin
			eot = (row_pos + 1 >= h);
			made[n] = '0;
			made[n].kind = KIND_RUN;
			made[n].idx = last_idx;
			made[n].run_length = LEN_W'(run_len);
			made[n].runs_in_line = LEN_W'(runs_done + 1);
			made[n].palette_count = eot ? PCNT_W'(colours_in_use) : '0;
			made[n].end_of_line = 1'b1;
			made[n].end_of_tile = eot;
			n++;
			col_pos = 0;
			run_len = 0;
			runs_done = 0;
			if (eot) begin
				row_pos = 0;
				colours_in_use = 0;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end

		if (n > 0)
			made[n-1].last_result = 1'b1;
		for (i = 0; i < n; i++)
			encoder_outputs_due.insert(encoder_outputs_due.size(), made[i]);
	endfunction

	task automatic flag_mismatch(string what);
		mismatch_count++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// Rising edge: note pixel handshakes for the predictor and compare result items
	// with the oldest due result.
	always @(posedge clk) begin
		prle_result_t seen;
		prle_result_t want;

		px_fired = arst_n && s_axis_tvalid && s_axis_tready;
		if (px_fired)
			encode_pixel(s_axis_tdata);

		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.kind = m_axis_tuser;
			seen.idx = m_axis_tdata[7:0];
			seen.red = m_axis_tdata[15:8];
			seen.green = m_axis_tdata[23:16];
			seen.blue = m_axis_tdata[31:24];
			seen.run_length = m_axis_tdata[44:32];
			seen.runs_in_line = m_axis_tdata[57:45];
			seen.palette_count = m_axis_tdata[65:58];
			seen.end_of_line = m_axis_tdata[66];
			seen.last_result = m_axis_tdata[67];
			seen.end_of_tile = m_axis_tlast;
			if (encoder_outputs_due.size() == 0) begin
				flag_mismatch("result item arrived with none due");
			end else begin
				want = encoder_outputs_due.pop_front();
				check_field("result_kind", seen.kind, want.kind);
				check_field("color_index", seen.idx, want.idx);
				check_field("red", seen.red, want.red);
				check_field("green", seen.green, want.green);
				check_field("blue", seen.blue, want.blue);
				check_field("run_length", seen.run_length, want.run_length);
				check_field("runs_in_line", seen.runs_in_line, want.runs_in_line);
				check_field("palette_count", seen.palette_count, want.palette_count);
				check_field("end_of_line", seen.end_of_line, want.end_of_line);
				check_field("end_of_tile", seen.end_of_tile, want.end_of_tile);
				check_field("last_result", seen.last_result, want.last_result);
			end
		end
	end

	// Pixel driver. A new item is offered only once the previous one has been taken,
	// after a random gap; occasionally a calm stretch offers items back to back.
	always @(negedge clk) begin
		if (arst_n) begin
			if (px_fired || !s_axis_tvalid) begin
				if (px_gap > 0) begin
					px_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pixels_to_send.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pixels_to_send.pop_front();
					if (px_calm > 0) begin
						px_calm--;
					end else begin
						px_gap = pick_gap();
						if ($urandom_range(0, 49) == 0)
							px_calm = $urandom_range(30, 120);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result sink: ready drops for random stretches, independently of valid.
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_stall > 0) begin
				res_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (res_calm > 0)
					res_calm--;
				else if ($urandom_range(0, 3) == 0)
					res_stall = pick_gap();
				else if ($urandom_range(0, 99) == 0)
					res_calm = $urandom_range(30, 150);
			end
		end
	end

	// Writes one size register; the predictor's copy follows at once, since writes
	// only happen while the encoder is idle.
	task automatic set_size(logic [CFG_IDX_W-1:0] which, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		if (which == CFG_LINE_WIDTH)
			line_width_q = value;
		else
			tile_height_q = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every pixel has been taken and every due result has come, then lets
	// a pixel that causes no result finish its walk along the palette chain.
	task automatic wait_until_quiet();
		while (pixels_to_send.size() != 0 || s_axis_tvalid || encoder_outputs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Adds one pixel at the back of the pending queue.
	task automatic queue_one(logic [PIXEL_W-1:0] px);
		pixels_to_send.insert(pixels_to_send.size(), px);
	endtask

	// Queues pixels drawn from a handful of tile colours, so that runs and palette hits
	// are common. change_pct is the chance of picking a new tile colour per pixel, and
	// noise_pct the chance of a wholly random colour. Alpha is always random.
	task automatic queue_pixels(int count, int ncolours, int change_pct, int noise_pct);
		logic [RGB_W-1:0] shades [6];
		logic [RGB_W-1:0] cur;
		int               k;

		for (k = 0; k < 6; k++)
			shades[k] = RGB_W'($urandom);
		cur = shades[0];
		repeat (count) begin
			if ($urandom_range(0, 99) < change_pct)
				cur = shades[$urandom_range(0, ncolours - 1)];
			if ($urandom_range(0, 99) < noise_pct)
				cur = RGB_W'($urandom);
			queue_one({cur, 8'($urandom)});
		end
	endtask

	initial begin
		int items_sent;
		int w;
		int h;
		int n;
		int half;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Sizes after reset are one by one: every pixel is a whole tile, so it brings a
		// palette entry and a closing run, and the palette empties each time.
		queue_one(32'h0000_0000);
		queue_one(32'hFFFF_FFFF);
		wait_until_quiet();

		// Four by two. The first line has a repeat with another alpha, a colour change
		// with a new colour, and a last pixel that causes all three results at once.
		// The second line opens on a known colour, changes to a known one, then to a
		// new one, and ends the tile with four colours in the palette.
		set_size(CFG_LINE_WIDTH, 13'd4);
		set_size(CFG_TILE_HEIGHT, 13'd2);
		queue_one(32'h1122_3344);
		queue_one(32'h1122_33AA);
		queue_one(32'h5566_7700);
		queue_one(32'hFF00_FF01);
		queue_one(32'h1122_3300);
		queue_one(32'h5566_7799);
		queue_one(32'h0000_0000);
		queue_one(32'h0000_00FF);
		wait_until_quiet();

		// Zero in both registers behaves as one.
		set_size(CFG_LINE_WIDTH, 13'd0);
		set_size(CFG_TILE_HEIGHT, 13'd0);
		queue_one(32'hA5A5_A5A5);
		queue_one(32'h5A5A_5A5A);
		wait_until_quiet();

		// Width above the maximum, then shrunk in the middle of the line: the next
		// pixel sits past the new width, so it closes both the line and the tile.
		set_size(CFG_LINE_WIDTH, 13'h1FFF);
		set_size(CFG_TILE_HEIGHT, 13'd1);
		queue_one(32'h0102_0300);
		queue_one(32'h0102_03FF);
		queue_one(32'h0A0B_0C00);
		queue_one(32'h0A0B_0C11);
		queue_one(32'h0A0B_0C22);
		wait_until_quiet();
		set_size(CFG_LINE_WIDTH, 13'd2);
		queue_one(32'h0A0B_0C33);
		wait_until_quiet();

		// Same idea for the height: several one-pixel lines, then the tile is cut short.
		set_size(CFG_LINE_WIDTH, 13'd1);
		set_size(CFG_TILE_HEIGHT, 13'h1FFF);
		queue_one(32'hFF00_0000);
		queue_one(32'h00FF_0000);
		queue_one(32'hFF00_0080);
		queue_one(32'h0000_FF00);
		wait_until_quiet();
		set_size(CFG_TILE_HEIGHT, 13'd2);
		queue_one(32'h00FF_00FF);
		wait_until_quiet();

		// A tile of random colours that overflows the palette; later unseen colours map
		// to index zero, and the tile ends with a full palette count.
		set_size(CFG_LINE_WIDTH, 13'd20);
		set_size(CFG_TILE_HEIGHT, 13'd13);
		queue_pixels(260, 1, 0, 100);
		wait_until_quiet();

		// Random tiles of mostly small sizes. Most phases send whole tiles; some stop
		// part-way so that the next sizes take effect in mid-line or mid-tile. In some
		// phases the sender stops half-way until every due result is in.
		items_sent = 0;
		while (items_sent < 60) begin
			case ($urandom_range(0, 9))
				0: w = 0;
				1: w = $urandom_range(9, 40);
				default: w = $urandom_range(1, 8);
			endcase
			h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
			set_size(CFG_LINE_WIDTH, CFG_W'(w));
			set_size(CFG_TILE_HEIGHT, CFG_W'(h));
			n = eff_size(CFG_W'(w)) * eff_size(CFG_W'(h)) * $urandom_range(1, 2);
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, n);
			if (n > 40)
				n = 40;
			if ($urandom_range(0, 3) == 0) begin
				half = n / 2;
				queue_pixels(half, $urandom_range(1, 6), 40, 5);
				wait_until_quiet();
				queue_pixels(n - half, $urandom_range(1, 6), 40, 5);
			end else begin
				queue_pixels(n, $urandom_range(1, 6), $urandom_range(10, 70), 5);
			end
			items_sent += n;
			wait_until_quiet();
		end

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, even with every stall at its longest.
	initial begin
		#24000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
